FILE: rtl/core/chained_hash_set_top_defines.svh
// Assertion macros for the chained hash set checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef CHAINED_HASH_SET_TOP_DEFINES_SVH
`define CHAINED_HASH_SET_TOP_DEFINES_SVH

// Same-cycle implication.
`define HS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hs_pkg.sv
`timescale 1ns / 1ps

package hs_pkg;

    localparam int KEY_W       = 31;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int BUCKET_W    = 4;
    localparam int BUCKETS_DEF = 13;
    localparam int WAYS_DEF    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEARCH = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2
    } hs_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } hs_status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MOD  = 2'd1,
        S_CMP  = 2'd2
    } hs_state_t;

endpackage

FILE: rtl/core/hs_req_if.sv
`timescale 1ns / 1ps

interface hs_req_if;
    logic                     valid;
    logic                     ready;
    logic [hs_pkg::MODE_W-1:0] mode;
    logic [hs_pkg::KEY_W-1:0]  key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

FILE: rtl/core/hs_rsp_if.sv
`timescale 1ns / 1ps

interface hs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [hs_pkg::STATUS_W-1:0] status;
    logic [hs_pkg::BUCKET_W-1:0] bucket;

    modport source (output valid, output found, output status, output bucket, input ready);
    modport sink   (input valid, input found, input status, input bucket, output ready);
endinterface

FILE: rtl/core/chained_hash_set_top.sv
`timescale 1ns / 1ps
// From request transaction to response valid: a two-step reciprocal key remainder,
// one bucket row read, one compare and write-back (held while a response stalls).
// Requests are taken one at a time; ready is high in the idle state only.
// A finished response waits in its output register while the next request runs.
// Reset (rst_n, asynchronous, active low) clears all slot valid bits at once;
// no clearing pass is needed. Key storage is undefined until written.
module chained_hash_set_top #(
    parameter int BUCKETS = hs_pkg::BUCKETS_DEF,
    parameter int WAYS    = hs_pkg::WAYS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hs_req_if.sink    req,
    hs_rsp_if.source  rsp
);

    localparam int BW    = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int KW    = hs_pkg::KEY_W;
    localparam int ROW_W = WAYS * KW;

    hs_pkg::hs_state_t  state_reg, state_next;
    logic [hs_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [BW-1:0]      bucket_reg, bucket_next;
    logic [WAYS-1:0]    valid_reg [BUCKETS];

    logic               rsp_valid_reg, rsp_valid_next;
    logic               found_reg, found_next;
    logic [hs_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [hs_pkg::BUCKET_W-1:0] rbucket_reg, rbucket_next;

    logic               mod_start;
    logic               mod_done;
    logic [BW-1:0]      mod_rem;

    logic               ram_we;
    logic               ram_re;
    logic [ROW_W-1:0]   row_rd;
    logic [ROW_W-1:0]   row_wr;

    logic [WAYS-1:0]    vrow;
    logic [WAYS-1:0]    hit;
    logic [WAYS-1:0]    free_vec;
    logic [WAYS-1:0]    free_oh;
    logic [WAYS-1:0]    vrow_new;
    logic               commit;
    logic               valid_we;
    logic               hit_any;
    logic               full;
    logic [BW+3:0]      bucket_ext;

    hs_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (req.key),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    hs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bucket_reg),
        .wdata (row_wr),
        .re    (ram_re),
        .raddr (mod_rem),
        .rdata (row_rd)
    );

    assign req.ready = (state_reg == hs_pkg::S_IDLE);
    assign mod_start = req.valid && req.ready;
    assign ram_re    = (state_reg == hs_pkg::S_MOD) && mod_done;

    // Parallel compare over the bucket row
    assign vrow = valid_reg[bucket_reg];

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w] = vrow[w] && (row_rd[w*KW +: KW] == key_reg);
        end
    end

    assign hit_any  = |hit;
    assign free_vec = ~vrow;
    assign free_oh  = free_vec & (~free_vec + WAYS'(1));
    assign full     = &vrow;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            row_wr[w*KW +: KW] = free_oh[w] ? key_reg : row_rd[w*KW +: KW];
        end
    end

    assign bucket_ext = {4'b0000, bucket_reg};
    assign commit     = (state_reg == hs_pkg::S_CMP) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        bucket_next    = bucket_reg;
        rsp_valid_next = rsp_valid_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rbucket_next   = rbucket_reg;
        ram_we         = 1'b0;
        valid_we       = 1'b0;
        vrow_new       = vrow;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            hs_pkg::S_IDLE:
            begin
                if (mod_start)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    state_next = hs_pkg::S_MOD;
                end
            end
            hs_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    bucket_next = mod_rem;
                    state_next  = hs_pkg::S_CMP;
                end
            end
            hs_pkg::S_CMP:
            begin
                if (commit)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = hit_any;
                    rbucket_next   = bucket_ext[3:0];
                    state_next     = hs_pkg::S_IDLE;
                    case (hs_pkg::hs_mode_t'(mode_reg))
                        hs_pkg::MODE_INSERT:
                        begin
                            if (hit_any)
                            begin
                                status_next = hs_pkg::ST_PRESENT;
                            end
                            else if (full)
                            begin
                                status_next = hs_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = hs_pkg::ST_DONE;
                                ram_we      = 1'b1;
                                valid_we    = 1'b1;
                                vrow_new    = vrow | free_oh;
                            end
                        end
                        hs_pkg::MODE_DELETE:
                        begin
                            if (hit_any)
                            begin
                                status_next = hs_pkg::ST_DONE;
                                valid_we    = 1'b1;
                                vrow_new    = vrow & ~hit;
                            end
                            else
                            begin
                                status_next = hs_pkg::ST_ABSENT;
                            end
                        end
                        default:
                        begin
                            status_next = hit_any ? hs_pkg::ST_DONE : hs_pkg::ST_ABSENT;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = hs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hs_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (valid_we)
            begin
                valid_reg[bucket_reg] <= vrow_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        bucket_reg  <= bucket_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        rbucket_reg <= rbucket_next;
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;
    assign rsp.bucket = rbucket_reg;

endmodule

FILE: rtl/core/hs_ram.sv
`timescale 1ns / 1ps

module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/hs_mod_unit.sv
`timescale 1ns / 1ps

// Remainder by reciprocal multiplication: product on start, then one
// multiply-back and subtract.
module hs_mod_unit #(
    parameter int BUCKETS = hs_pkg::BUCKETS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [hs_pkg::KEY_W-1:0]                    key,
    output logic                                        done,
    output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] rem
);

    localparam int BW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int KW = hs_pkg::KEY_W;
    localparam int RW = 32;
    localparam int PW = KW + RW;
    localparam int SH = KW + $clog2(BUCKETS);
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [KW-1:0]    key_reg, key_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [BW-1:0]    rem_reg, rem_next;
    logic [PW-SH-1:0] quot;
    logic [KW-1:0]    diff;

    assign quot = prod_reg[PW-1:SH];
    assign diff = key_reg - KW'(quot) * KW'(BUCKETS);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        key_next  = key_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            key_next  = key;
            prod_next = PW'(key) * PW'(RECIP);
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            rem_next  = diff[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/core/hs_checker.sv
`timescale 1ns / 1ps
`include "chained_hash_set_top_defines.svh"

module hs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic [hs_pkg::STATUS_W-1:0] rsp_status
);

    `HS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
    `HS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready high after request")
    `HS_ASSERT_NOW(a_found_status, rsp_valid && rsp_found, (rsp_status == hs_pkg::ST_DONE) || (rsp_status == hs_pkg::ST_PRESENT), "found with miss status")
    `HS_ASSERT_NOW(a_miss_status, rsp_valid && !rsp_found, rsp_status != hs_pkg::ST_PRESENT, "present status without hit")

endmodule

bind chained_hash_set_top hs_checker u_hs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_found  (rsp.found),
    .rsp_status (rsp.status)
);
